/* sv/sts_pkg.sv */
// shared types, codes and character classifiers for the source token scanner
package sts_pkg;

   // line counter width
   localparam int LINE_BITS = 16;
   // width of the line number shown on a result
   localparam int LINE_OUT_BITS = 16;
   // depth of the queue between scanner front and result back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   // most results one input item can cause
   localparam int MAX_RESULTS = 3;

   // scanner modes
   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_IDENT     = 3'd1,
      MODE_INT       = 3'd2,
      MODE_REL       = 3'd3,
      MODE_CHR_OPEN  = 3'd4,
      MODE_CHR_CLOSE = 3'd5,
      MODE_STR_FIRST = 3'd6,
      MODE_STR       = 3'd7
   } mode_type;

   // token types
   typedef enum logic [2:0] {
      TOK_IDENT = 3'd0,
      TOK_INT   = 3'd1,
      TOK_CHAR  = 3'd2,
      TOK_STR   = 3'd3,
      TOK_OTHER = 3'd4
   } tok_kind_type;

   // error codes
   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_BAD_CHAR = 3'd1,
      ERR_EMPTY    = 3'd2,
      ERR_NO_QUOTE = 3'd3,
      ERR_BANG     = 3'd4,
      ERR_UNKNOWN  = 3'd5,
      ERR_UNTERM   = 3'd6
   } err_type;

   // result kinds
   typedef enum logic {
      KIND_CHAR = 1'b0,
      KIND_END  = 1'b1
   } res_kind_type;

   // classes of a byte at the start of a token
   typedef enum logic [2:0] {
      CL_BLANK  = 3'd0,
      CL_LETTER = 3'd1,
      CL_DIGIT  = 3'd2,
      CL_SQUOTE = 3'd3,
      CL_DQUOTE = 3'd4,
      CL_REL    = 3'd5,
      CL_PUNCT  = 3'd6,
      CL_OTHER  = 3'd7
   } char_class_type;

   // special characters
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_STR_LO  = 8'h23;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_TILDE   = 8'h7E;

   // one result of the scanner
   typedef struct packed {
      res_kind_type kind;
      logic [7:0]   tok_char;
      tok_kind_type token_type;
      err_type      error_code;
   } result_type;

   // all results of one input item, sharing one line number
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [1:0]                   count;
      logic [LINE_OUT_BITS-1:0]     line_no;
   } bundle_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } head_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c == CH_UNDER) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // characters allowed in a char literal
   function automatic logic is_lit_char(input logic [7:0] c);
      return is_letter(c) || is_digit(c) || c == 8'h2B || c == 8'h2D || c == 8'h2A ||
             c == 8'h2F;
   endfunction

   // characters kept in a string literal
   function automatic logic is_str_char(input logic [7:0] c);
      return (c >= CH_STR_LO && c <= CH_TILDE) || c == CH_SPACE || c == CH_BANG;
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F || c == 8'h28 ||
             c == 8'h29 || c == 8'h5B || c == 8'h5D || c == 8'h7B || c == 8'h7D ||
             c == 8'h2C || c == 8'h3A || c == 8'h3B;
   endfunction

   // class of a byte that opens a token
   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type cl;
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NEWLINE) begin
         cl = CL_BLANK;
      end else if (is_letter(c)) begin
         cl = CL_LETTER;
      end else if (is_digit(c)) begin
         cl = CL_DIGIT;
      end else if (c == CH_SQUOTE) begin
         cl = CL_SQUOTE;
      end else if (c == CH_DQUOTE) begin
         cl = CL_DQUOTE;
      end else if (c == 8'h3E || c == 8'h3C || c == CH_EQUAL || c == CH_BANG) begin
         cl = CL_REL;
      end else if (is_punct(c)) begin
         cl = CL_PUNCT;
      end else begin
         cl = CL_OTHER;
      end
      return cl;
   endfunction

   // keep the first error of a token
   function automatic err_type first_err(input err_type cur, input err_type e);
      return (cur == ERR_NONE) ? e : cur;
   endfunction

   // line count as shown on a result, capped at the output width
   function automatic logic [LINE_OUT_BITS-1:0] shown_line(input logic [LINE_BITS-1:0] v);
      logic [32:0] w;
      logic [32:0] top;
      w   = 33'(v);
      top = 33'({LINE_OUT_BITS{1'b1}});
      return (w > top) ? top[LINE_OUT_BITS-1:0] : w[LINE_OUT_BITS-1:0];
   endfunction

   // one result record
   function automatic result_type mk_result(input res_kind_type k, input logic [7:0] c,
                                            input tok_kind_type t, input err_type e);
      result_type r;
      r.kind       = k;
      r.tok_char   = c;
      r.token_type = t;
      r.error_code = e;
      return r;
   endfunction

endpackage

/* sv/sts_front.sv */
// scanner front end: takes one byte per cycle while accept is high, tracks token state, builds result bundles
module sts_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          ch,
   input  logic                is_end,
   output logic                bundle_push,
   output sts_pkg::bundle_type bundle
);

   // per-step decisions on the token in progress
   typedef struct packed {
      logic                  cur_emit;
      sts_pkg::tok_kind_type cur_emit_type;
      logic                  cur_end;
      sts_pkg::tok_kind_type cur_end_type;
      sts_pkg::err_type      cur_end_err;
      logic                  restart;
      sts_pkg::mode_type     mode_next;
      sts_pkg::err_type      err_next;
   } step_type;

   sts_pkg::mode_type        mode_ff, mode_in;
   logic [sts_pkg::LINE_BITS-1:0] line_ff, line_in;
   logic                     bang_ff, bang_in;
   sts_pkg::err_type         err_ff, err_in;
   sts_pkg::char_class_type  cls;
   step_type                 st;
   logic [1:0]               cnt;

   assign cls = sts_pkg::classify(ch);

   // decide what happens to the token in progress
   always_comb begin
      st               = '0;
      st.cur_emit_type = sts_pkg::TOK_OTHER;
      st.cur_end_type  = sts_pkg::TOK_OTHER;
      st.cur_end_err   = err_ff;
      st.mode_next     = mode_ff;
      st.err_next      = err_ff;
      if (is_end) begin
         st.mode_next = sts_pkg::MODE_IDLE;
         unique case (mode_ff)
            sts_pkg::MODE_IDENT: begin
               st.cur_end      = 1'b1;
               st.cur_end_type = sts_pkg::TOK_IDENT;
            end
            sts_pkg::MODE_INT: begin
               st.cur_end      = 1'b1;
               st.cur_end_type = sts_pkg::TOK_INT;
            end
            sts_pkg::MODE_REL: begin
               st.cur_end = 1'b1;
               if (bang_ff) begin
                  st.cur_end_err = sts_pkg::first_err(err_ff, sts_pkg::ERR_BANG);
               end
            end
            sts_pkg::MODE_CHR_OPEN, sts_pkg::MODE_CHR_CLOSE: begin
               st.cur_end      = 1'b1;
               st.cur_end_type = sts_pkg::TOK_CHAR;
               st.cur_end_err  = sts_pkg::first_err(err_ff, sts_pkg::ERR_UNTERM);
            end
            sts_pkg::MODE_STR_FIRST, sts_pkg::MODE_STR: begin
               st.cur_end      = 1'b1;
               st.cur_end_type = sts_pkg::TOK_STR;
               st.cur_end_err  = sts_pkg::first_err(err_ff, sts_pkg::ERR_UNTERM);
            end
            default: begin
            end
         endcase
      end else begin
         unique case (mode_ff)
            sts_pkg::MODE_IDENT: begin
               st.cur_emit_type = sts_pkg::TOK_IDENT;
               st.cur_end_type  = sts_pkg::TOK_IDENT;
               if (sts_pkg::is_letter(ch) || sts_pkg::is_digit(ch)) begin
                  st.cur_emit = 1'b1;
               end else begin
                  st.cur_end = 1'b1;
                  st.restart = 1'b1;
               end
            end
            sts_pkg::MODE_INT: begin
               st.cur_emit_type = sts_pkg::TOK_INT;
               st.cur_end_type  = sts_pkg::TOK_INT;
               if (sts_pkg::is_digit(ch)) begin
                  st.cur_emit = 1'b1;
               end else begin
                  st.cur_end = 1'b1;
                  st.restart = 1'b1;
               end
            end
            sts_pkg::MODE_REL: begin
               st.cur_end = 1'b1;
               if (ch == sts_pkg::CH_EQUAL) begin
                  st.cur_emit = 1'b1;
               end else begin
                  st.restart = 1'b1;
                  if (bang_ff) begin
                     st.cur_end_err = sts_pkg::first_err(err_ff, sts_pkg::ERR_BANG);
                  end
               end
            end
            sts_pkg::MODE_CHR_OPEN: begin
               st.cur_emit_type = sts_pkg::TOK_CHAR;
               st.cur_end_type  = sts_pkg::TOK_CHAR;
               if (ch == sts_pkg::CH_SQUOTE) begin
                  st.cur_end     = 1'b1;
                  st.cur_end_err = sts_pkg::first_err(err_ff, sts_pkg::ERR_EMPTY);
               end else begin
                  st.mode_next = sts_pkg::MODE_CHR_CLOSE;
                  if (sts_pkg::is_lit_char(ch)) begin
                     st.cur_emit = 1'b1;
                  end else begin
                     st.err_next = sts_pkg::first_err(err_ff, sts_pkg::ERR_BAD_CHAR);
                  end
               end
            end
            sts_pkg::MODE_CHR_CLOSE: begin
               st.cur_end      = 1'b1;
               st.cur_end_type = sts_pkg::TOK_CHAR;
               if (ch != sts_pkg::CH_SQUOTE) begin
                  st.cur_end_err = sts_pkg::first_err(err_ff, sts_pkg::ERR_NO_QUOTE);
               end
            end
            sts_pkg::MODE_STR_FIRST, sts_pkg::MODE_STR: begin
               st.cur_emit_type = sts_pkg::TOK_STR;
               st.cur_end_type  = sts_pkg::TOK_STR;
               if (ch == sts_pkg::CH_DQUOTE) begin
                  st.cur_end = 1'b1;
                  if (mode_ff == sts_pkg::MODE_STR_FIRST) begin
                     st.cur_end_err = sts_pkg::first_err(err_ff, sts_pkg::ERR_EMPTY);
                  end
               end else begin
                  st.mode_next = sts_pkg::MODE_STR;
                  if (sts_pkg::is_str_char(ch)) begin
                     st.cur_emit = 1'b1;
                  end else begin
                     st.err_next = sts_pkg::first_err(err_ff, sts_pkg::ERR_BAD_CHAR);
                  end
               end
            end
            default: begin
               st.restart = 1'b1;
            end
         endcase
      end
   end

   // next scanner state
   always_comb begin
      mode_in = mode_ff;
      err_in  = err_ff;
      bang_in = bang_ff;
      line_in = line_ff;
      if (accept) begin
         if (is_end || st.cur_end) begin
            mode_in = sts_pkg::MODE_IDLE;
            err_in  = sts_pkg::ERR_NONE;
            bang_in = 1'b0;
         end else begin
            mode_in = st.mode_next;
            err_in  = st.err_next;
         end
         if (st.restart) begin
            unique case (cls)
               sts_pkg::CL_BLANK: begin
                  if (ch == sts_pkg::CH_NEWLINE && line_ff != {sts_pkg::LINE_BITS{1'b1}}) begin
                     line_in = line_ff + 1'b1;
                  end
               end
               sts_pkg::CL_LETTER: mode_in = sts_pkg::MODE_IDENT;
               sts_pkg::CL_DIGIT:  mode_in = sts_pkg::MODE_INT;
               sts_pkg::CL_SQUOTE: mode_in = sts_pkg::MODE_CHR_OPEN;
               sts_pkg::CL_DQUOTE: mode_in = sts_pkg::MODE_STR_FIRST;
               sts_pkg::CL_REL: begin
                  mode_in = sts_pkg::MODE_REL;
                  bang_in = (ch == sts_pkg::CH_BANG);
               end
               default: mode_in = sts_pkg::MODE_IDLE;
            endcase
         end
      end
   end

   // results of this item, in order
   always_comb begin
      bundle         = '0;
      bundle.line_no = sts_pkg::shown_line(line_ff);
      cnt            = 2'd0;
      if (st.cur_emit) begin
         bundle.res[cnt] = sts_pkg::mk_result(sts_pkg::KIND_CHAR, ch, st.cur_emit_type,
                                              sts_pkg::ERR_NONE);
         cnt = cnt + 2'd1;
      end
      if (st.cur_end) begin
         bundle.res[cnt] = sts_pkg::mk_result(sts_pkg::KIND_END, 8'h00, st.cur_end_type,
                                              st.cur_end_err);
         cnt = cnt + 2'd1;
      end
      if (st.restart) begin
         unique case (cls)
            sts_pkg::CL_LETTER: begin
               bundle.res[cnt] = sts_pkg::mk_result(sts_pkg::KIND_CHAR, ch,
                                                    sts_pkg::TOK_IDENT, sts_pkg::ERR_NONE);
               cnt = cnt + 2'd1;
            end
            sts_pkg::CL_DIGIT: begin
               bundle.res[cnt] = sts_pkg::mk_result(sts_pkg::KIND_CHAR, ch,
                                                    sts_pkg::TOK_INT, sts_pkg::ERR_NONE);
               cnt = cnt + 2'd1;
            end
            sts_pkg::CL_REL: begin
               bundle.res[cnt] = sts_pkg::mk_result(sts_pkg::KIND_CHAR, ch,
                                                    sts_pkg::TOK_OTHER, sts_pkg::ERR_NONE);
               cnt = cnt + 2'd1;
            end
            sts_pkg::CL_PUNCT: begin
               bundle.res[cnt] = sts_pkg::mk_result(sts_pkg::KIND_CHAR, ch,
                                                    sts_pkg::TOK_OTHER, sts_pkg::ERR_NONE);
               cnt = cnt + 2'd1;
               bundle.res[cnt] = sts_pkg::mk_result(sts_pkg::KIND_END, 8'h00,
                                                    sts_pkg::TOK_OTHER, sts_pkg::ERR_NONE);
               cnt = cnt + 2'd1;
            end
            sts_pkg::CL_OTHER: begin
               bundle.res[cnt] = sts_pkg::mk_result(sts_pkg::KIND_END, 8'h00,
                                                    sts_pkg::TOK_OTHER, sts_pkg::ERR_UNKNOWN);
               cnt = cnt + 2'd1;
            end
            default: begin
            end
         endcase
      end
      bundle.count = cnt;
   end

   assign bundle_push = accept && (cnt != 2'd0);

   // scanner state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sts_pkg::MODE_IDLE;
         line_ff <= sts_pkg::LINE_BITS'(1);
         bang_ff <= 1'b0;
         err_ff  <= sts_pkg::ERR_NONE;
      end else begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         bang_ff <= bang_in;
         err_ff  <= err_in;
      end
   end

endmodule

/* sv/sts_queue.sv */
// short queue of result bundles between scanner front and back end
module sts_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sts_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output sts_pkg::head_type   head
);

   sts_pkg::bundle_type                   slots_ff [sts_pkg::QUEUE_DEPTH];
   logic [sts_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sts_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sts_pkg::QUEUE_PTR_BITS:0]      fill_ff, fill_in;
   logic                                  do_push;
   logic                                  do_pop;

   assign full        = (fill_ff == (sts_pkg::QUEUE_PTR_BITS+1)'(sts_pkg::QUEUE_DEPTH));
   assign head.valid  = (fill_ff != '0);
   assign head.bundle = slots_ff[rd_ptr_ff];
   assign do_push     = push && !full;
   assign do_pop      = pop && head.valid;

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // bundle storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/sts_back.sv */
// back end: hands out the results of each queued bundle one item at a time
module sts_back (
   input  logic              clock,
   input  logic              reset,
   input  sts_pkg::head_type head,
   output logic              bundle_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_kind,
   output logic [7:0]        rsp_tok_char,
   output logic [2:0]        rsp_token_type,
   output logic [15:0]       rsp_line_no,
   output logic [2:0]        rsp_error_code,
   output logic              rsp_last
);

   logic [1:0]           idx_ff, idx_in;
   logic                 take;
   logic                 at_last;
   sts_pkg::result_type  cur;

   assign cur     = head.bundle.res[idx_ff];
   assign at_last = (idx_ff == head.bundle.count - 2'd1);
   assign take    = rsp_pop && head.valid;

   // result ports
   assign rsp_empty      = !head.valid;
   assign rsp_kind       = cur.kind;
   assign rsp_tok_char   = cur.tok_char;
   assign rsp_token_type = cur.token_type;
   assign rsp_error_code = cur.error_code;
   assign rsp_line_no    = head.bundle.line_no;
   assign rsp_last       = at_last;

   // step through the bundle, release it after its last result
   assign bundle_pop = take && at_last;
   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

/* sv/source_token_scanner.sv */
// top level of the source token scanner
// Scans one source byte per cycle (or an end marker) into token results: a token-char
// item for each kept character and an end item carrying type, line and first error.
// An input item is taken every cycle while a four-bundle queue between the scanner and
// the result port has room; each input item gives zero to three results, and the result
// port hands out one result per cycle, so sustained input rate is one byte per cycle as
// long as results average at most one per byte and the consumer pops every cycle.
// Results of an accepted item are registered in the bundle queue before they reach the port.
module source_token_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_ch,
   input  logic        req_is_end,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_kind,
   output logic [7:0]  rsp_tok_char,
   output logic [2:0]  rsp_token_type,
   output logic [15:0] rsp_line_no,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last
);

   logic                accept;
   logic                bundle_push;
   logic                bundle_pop;
   sts_pkg::bundle_type bundle;
   sts_pkg::head_type   head;

   assign accept = req_push && !req_full;

   // scanner front end
   sts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ch          (req_ch),
      .is_end      (req_is_end),
      .bundle_push (bundle_push),
      .bundle      (bundle)
   );

   // bundle queue
   sts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (bundle_push),
      .push_data (bundle),
      .full      (req_full),
      .pop       (bundle_pop),
      .head      (head)
   );

   // result back end
   sts_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .bundle_pop     (bundle_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_tok_char   (rsp_tok_char),
      .rsp_token_type (rsp_token_type),
      .rsp_line_no    (rsp_line_no),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule

/* dv/source_token_scanner_tb.sv */
// testbench for the source token scanner: byte stream in, token results checked in order
module source_token_scanner_tb;
   import sts_pkg::*;

   localparam int IDLE_PCT      = 18;
   localparam int RANDOM_ITEMS  = 135;
   localparam int CALM_ITEMS    = 40;
   localparam int PAUSE_AT      = 100;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_REPORTS   = 100;
   localparam int N_STEPS       = 25;

   // one expected result of the scanner
   typedef struct packed {
      res_kind_type kind;
      logic [7:0]   ch;
      tok_kind_type ttype;
      logic [15:0]  line;
      err_type      err;
      logic         last;
   } scan_result_t;

   // one row of the directed table; want is used only where typed is set
   typedef struct packed {
      logic [7:0]   ch;
      logic         is_end;
      logic         typed;
      scan_result_t want;
   } step_t;

   localparam scan_result_t NO_WANT = '{KIND_CHAR, 8'h00, TOK_IDENT, 16'd0, ERR_NONE, 1'b0};

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_push   = 1'b0;
   logic        req_full;
   logic [7:0]  req_ch     = 8'h00;
   logic        req_is_end = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop    = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_tok_char;
   logic [2:0]  rsp_token_type;
   logic [15:0] rsp_line_no;
   logic [2:0]  rsp_error_code;
   logic        rsp_last;

   // scanner state as the checker sees it
   mode_type    scan_state = MODE_IDLE;
   logic [15:0] line_count = 16'd1;
   logic        bang_open  = 1'b0;
   err_type     tok_err    = ERR_NONE;

   scan_result_t tokens_due[$];
   logic [8:0]   plan[$];
   int           mismatches  = 0;
   int           cycle_count = 0;
   bit           calm        = 1'b0;

   // directed rows: extremes, every token class and each error code except ERR_NO_QUOTE
   step_t steps [N_STEPS] = '{
      '{8'h80, 1'b0, 1'b1, '{KIND_END, 8'h00, TOK_OTHER, 16'd1, ERR_UNKNOWN, 1'b1}},
      '{8'hFF, 1'b0, 1'b1, '{KIND_END, 8'h00, TOK_OTHER, 16'd1, ERR_UNKNOWN, 1'b1}},
      '{"A",   1'b0, 1'b0, NO_WANT},
      '{"z",   1'b0, 1'b0, NO_WANT},
      '{"9",   1'b0, 1'b0, NO_WANT},
      '{"_",   1'b0, 1'b0, NO_WANT},
      '{8'h0A, 1'b0, 1'b0, NO_WANT},
      '{"0",   1'b0, 1'b0, NO_WANT},
      '{">",   1'b0, 1'b0, NO_WANT},
      '{"=",   1'b0, 1'b0, NO_WANT},
      '{"!",   1'b0, 1'b0, NO_WANT},
      '{"~",   1'b0, 1'b0, NO_WANT},
      '{8'h09, 1'b0, 1'b0, NO_WANT},
      '{8'h27, 1'b0, 1'b0, NO_WANT},
      '{8'h27, 1'b0, 1'b1, '{KIND_END, 8'h00, TOK_CHAR, 16'd2, ERR_EMPTY, 1'b1}},
      '{8'h27, 1'b0, 1'b0, NO_WANT},
      '{"#",   1'b0, 1'b0, NO_WANT},
      '{8'h27, 1'b0, 1'b1, '{KIND_END, 8'h00, TOK_CHAR, 16'd2, ERR_BAD_CHAR, 1'b1}},
      '{8'h22, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{"!",   1'b0, 1'b0, NO_WANT},
      '{8'h22, 1'b0, 1'b0, NO_WANT},
      '{8'h22, 1'b0, 1'b0, NO_WANT},
      '{8'hFF, 1'b1, 1'b1, '{KIND_END, 8'h00, TOK_STR, 16'd2, ERR_UNTERM, 1'b1}},
      '{8'h00, 1'b1, 1'b0, NO_WANT}
   };

   source_token_scanner i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_ch         (req_ch),
      .req_is_end     (req_is_end),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_tok_char   (rsp_tok_char),
      .rsp_token_type (rsp_token_type),
      .rsp_line_no    (rsp_line_no),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   // clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // byte classes
   function automatic logic letter_byte(input logic [7:0] c);
      return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic digit_byte(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic lit_byte(input logic [7:0] c);
      return letter_byte(c) || digit_byte(c) || c == "+" || c == "-" || c == "*" || c == "/";
   endfunction

   function automatic logic str_byte(input logic [7:0] c);
      return (c >= 8'd35 && c <= 8'd126) || c == 8'd32 || c == 8'd33;
   endfunction

   function automatic logic punct_byte(input logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "(" || c == ")" ||
             c == "[" || c == "]" || c == "{" || c == "}" || c == "," || c == ":" ||
             c == ";";
   endfunction

   // append one result to the list of results due
   function automatic void due_add(input scan_result_t r);
      tokens_due.insert(tokens_due.size(), r);
   endfunction

   // token char and token end results
   function automatic void emit_token_char(input logic [7:0] c, input tok_kind_type t);
      due_add('{KIND_CHAR, c, t, line_count, ERR_NONE, 1'b0});
   endfunction

   function automatic void close_token(input tok_kind_type t);
      due_add('{KIND_END, 8'h00, t, line_count, tok_err, 1'b0});
      tok_err    = ERR_NONE;
      bang_open  = 1'b0;
      scan_state = MODE_IDLE;
   endfunction

   function automatic void note_err(input err_type e);
      if (tok_err == ERR_NONE) begin
         tok_err = e;
      end
   endfunction

   // a byte seen between tokens
   function automatic void open_token(input logic [7:0] c);
      if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
         if (c == 8'h0A && line_count != 16'hFFFF) begin
            line_count = line_count + 16'd1;
         end
      end else if (letter_byte(c)) begin
         emit_token_char(c, TOK_IDENT);
         scan_state = MODE_IDENT;
      end else if (digit_byte(c)) begin
         emit_token_char(c, TOK_INT);
         scan_state = MODE_INT;
      end else if (c == 8'h27) begin
         scan_state = MODE_CHR_OPEN;
      end else if (c == 8'h22) begin
         scan_state = MODE_STR_FIRST;
      end else if (c == ">" || c == "<" || c == "=" || c == "!") begin
         emit_token_char(c, TOK_OTHER);
         bang_open  = (c == "!");
         scan_state = MODE_REL;
      end else if (punct_byte(c)) begin
         emit_token_char(c, TOK_OTHER);
         close_token(TOK_OTHER);
      end else begin
         note_err(ERR_UNKNOWN);
         close_token(TOK_OTHER);
      end
   endfunction

   // expected results of one accepted item, appended to tokens_due
   function automatic void scan_byte(input logic [7:0] c, input logic e);
      int base;
      base = tokens_due.size();
      if (e) begin
         case (scan_state)
            MODE_IDENT: close_token(TOK_IDENT);
            MODE_INT:   close_token(TOK_INT);
            MODE_REL: begin
               if (bang_open) begin
                  note_err(ERR_BANG);
               end
               close_token(TOK_OTHER);
            end
            MODE_CHR_OPEN, MODE_CHR_CLOSE: begin
               note_err(ERR_UNTERM);
               close_token(TOK_CHAR);
            end
            MODE_STR_FIRST, MODE_STR: begin
               note_err(ERR_UNTERM);
               close_token(TOK_STR);
            end
            default: ;
         endcase
         scan_state = MODE_IDLE;
         bang_open  = 1'b0;
         tok_err    = ERR_NONE;
      end else begin
         case (scan_state)
            MODE_IDENT: begin
               if (letter_byte(c) || digit_byte(c)) begin
                  emit_token_char(c, TOK_IDENT);
               end else begin
                  close_token(TOK_IDENT);
                  open_token(c);
               end
            end
            MODE_INT: begin
               if (digit_byte(c)) begin
                  emit_token_char(c, TOK_INT);
               end else begin
                  close_token(TOK_INT);
                  open_token(c);
               end
            end
            MODE_REL: begin
               if (c == "=") begin
                  emit_token_char(c, TOK_OTHER);
                  close_token(TOK_OTHER);
               end else begin
                  if (bang_open) begin
                     note_err(ERR_BANG);
                  end
                  close_token(TOK_OTHER);
                  open_token(c);
               end
            end
            MODE_CHR_OPEN: begin
               if (c == 8'h27) begin
                  note_err(ERR_EMPTY);
                  close_token(TOK_CHAR);
               end else begin
                  if (lit_byte(c)) begin
                     emit_token_char(c, TOK_CHAR);
                  end else begin
                     note_err(ERR_BAD_CHAR);
                  end
                  scan_state = MODE_CHR_CLOSE;
               end
            end
            MODE_CHR_CLOSE: begin
               if (c != 8'h27) begin
                  note_err(ERR_NO_QUOTE);
               end
               close_token(TOK_CHAR);
            end
            MODE_STR_FIRST, MODE_STR: begin
               if (c == 8'h22) begin
                  if (scan_state == MODE_STR_FIRST) begin
                     note_err(ERR_EMPTY);
                  end
                  close_token(TOK_STR);
               end else begin
                  if (str_byte(c)) begin
                     emit_token_char(c, TOK_STR);
                  end else begin
                     note_err(ERR_BAD_CHAR);
                  end
                  scan_state = MODE_STR;
               end
            end
            default: open_token(c);
         endcase
      end
      // the final result of this item carries last
      if (tokens_due.size() > base) begin
         tokens_due[tokens_due.size() - 1].last = 1'b1;
      end
   endfunction

   // random source text pieces
   function automatic logic [7:0] rand_letter();
      logic [7:0] c;
      case ($urandom_range(0, 2))
         0:       c = 8'(8'h61 + $urandom_range(0, 25));
         1:       c = 8'(8'h41 + $urandom_range(0, 25));
         default: c = "_";
      endcase
      return c;
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'(8'h30 + $urandom_range(0, 9));
   endfunction

   function automatic void add_bytes(input logic [7:0] c);
      plan.insert(plan.size(), {1'b0, c});
   endfunction

   function automatic void add_snippet();
      string puncts;
      int    n;
      int    k;
      puncts = "+-*/()[]{},:;";
      case ($urandom_range(0, 19))
         0, 1, 2, 3: begin
            add_bytes(rand_letter());
            n = $urandom_range(0, 5);
            for (k = 0; k < n; k++) begin
               add_bytes($urandom_range(0, 1) ? rand_letter() : rand_digit());
            end
         end
         4, 5: begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
               add_bytes(rand_digit());
            end
         end
         6, 7: begin
            add_bytes(8'h27);
            case ($urandom_range(0, 5))
               0: add_bytes(8'h27);
               1: begin
                  add_bytes(8'($urandom_range(0, 255)));
                  add_bytes(8'h27);
               end
               2: begin
                  add_bytes(rand_letter());
                  add_bytes(8'($urandom_range(0, 255)));
               end
               default: begin
                  add_bytes($urandom_range(0, 1) ? rand_letter() : puncts[$urandom_range(0, 3)]);
                  add_bytes(8'h27);
               end
            endcase
         end
         8, 9: begin
            add_bytes(8'h22);
            n = $urandom_range(0, 6);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(0, 5) == 0) begin
                  add_bytes(8'($urandom_range(0, 255)));
               end else begin
                  add_bytes(8'($urandom_range(35, 126)));
               end
            end
            add_bytes(8'h22);
         end
         10, 11: begin
            case ($urandom_range(0, 3))
               0:       add_bytes(">");
               1:       add_bytes("<");
               2:       add_bytes("=");
               default: add_bytes("!");
            endcase
            if ($urandom_range(0, 1)) begin
               add_bytes("=");
            end
         end
         12, 13: add_bytes(puncts[$urandom_range(0, puncts.len() - 1)]);
         14, 15: begin
            case ($urandom_range(0, 3))
               0:       add_bytes(" ");
               1:       add_bytes(8'h09);
               2:       add_bytes(8'h0D);
               default: add_bytes(8'h0A);
            endcase
         end
         16: add_bytes(8'($urandom_range(0, 255)));
         17: plan.insert(plan.size(), {1'b1, 8'($urandom_range(0, 255))});
         18: begin
            // literal cut short by the end of input
            add_bytes($urandom_range(0, 1) ? 8'h27 : 8'h22);
            n = $urandom_range(0, 2);
            for (k = 0; k < n; k++) begin
               add_bytes(rand_letter());
            end
            plan.insert(plan.size(), {1'b1, 8'($urandom_range(0, 255))});
         end
         default: add_bytes(8'($urandom_range(128, 255)));
      endcase
   endfunction

   // offer one item, wait for it to be taken, then note what it should cause
   task automatic send_item(input logic [7:0] c, input logic e, input logic typed,
                            input scan_result_t want);
      int base;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push   <= 1'b1;
      req_ch     <= c;
      req_is_end <= e;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      base = tokens_due.size();
      scan_byte(c, e);
      if (typed) begin
         while (tokens_due.size() > base) begin
            void'(tokens_due.pop_back());
         end
         due_add(want);
      end
      @(negedge clock);
   endtask

   // hold the input until every result due has come out
   task automatic drain();
      req_push <= 1'b0;
      while (tokens_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         end
      end
   endfunction

   // result side: random pop stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // compare each popped item with the oldest one due
   always @(posedge clock) begin
      scan_result_t want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (tokens_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: unexpected item expected none got kind %0d char %0h type %0d",
                        $time, rsp_kind, rsp_tok_char, rsp_token_type);
            end
         end else begin
            want = tokens_due.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_kind));
            check_field("tok_char", 16'(want.ch), 16'(rsp_tok_char));
            check_field("token_type", 16'(want.ttype), 16'(rsp_token_type));
            check_field("line_no", want.line, rsp_line_no);
            check_field("error_code", 16'(want.err), 16'(rsp_error_code));
            check_field("last", 16'(want.last), 16'(rsp_last));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // stimulus
   initial begin
      int         i;
      int         sent;
      logic [8:0] piece;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (i = 0; i < N_STEPS; i++) begin
         send_item(steps[i].ch, steps[i].is_end, steps[i].typed, steps[i].want);
      end
      drain();

      // random source text, the first stretch without stalls
      calm = 1'b1;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent == CALM_ITEMS) begin
            calm = 1'b0;
         end
         if (sent == PAUSE_AT) begin
            drain();
         end
         if (plan.size() == 0) begin
            add_snippet();
         end
         piece = plan.pop_front();
         send_item(piece[7:0], piece[8], 1'b0, NO_WANT);
         sent++;
      end

      // wait for the last results, then a few quiet cycles
      req_push <= 1'b0;
      while (tokens_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && tokens_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/sts_pkg.sv
sv/sts_front.sv
sv/sts_queue.sv
sv/sts_back.sv
sv/source_token_scanner.sv
dv/source_token_scanner_tb.sv
